FILE: hdl/plrt_pkg.sv
// Shared constants, widths and structs of the piecewise linear ramp table generator.
// Used by the channel interfaces, the point store, the divider and the top level.
`default_nettype none

package plrt_pkg;

  // Point store and fixed point format
  localparam int MAX_POINTS     = 256;
  localparam int GRAD_FRAC_BITS = 24;
  localparam int ENTRY_STRIDE   = 4;

  localparam int X_W      = 12;
  localparam int Y_W      = 12;
  localparam int FUNC_W   = 2;
  localparam int TS_W     = 13;
  localparam int CHAN_W   = $clog2(ENTRY_STRIDE);
  localparam int ADDR_W   = X_W + CHAN_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = TS_W;

  localparam int PT_AW = $clog2(MAX_POINTS);
  localparam int PT_CW = PT_AW + 1;

  // Value: unsigned Q1.16
  localparam int VAL_FRAC_W = 16;
  localparam int VAL_W      = VAL_FRAC_W + 1;
  localparam logic [VAL_W-1:0] VAL_MAX = VAL_W'(1) << VAL_FRAC_W;

  // Divider and accumulator widths
  localparam int DIV_NUM_W = Y_W + GRAD_FRAC_BITS;
  localparam int DIV_DEN_W = X_W + Y_W;
  localparam int GRAD_W    = DIV_NUM_W + 1;
  localparam int ACC_W     = DIV_NUM_W + X_W + 2;

  // Longest pass: one entry per x step
  localparam logic [TS_W-1:0] TS_CAP = TS_W'(1) << X_W;

  // Input operation codes
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EMIT   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL    = 2'd3;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic             we;
    logic [PT_AW-1:0] wr_addr;
    point_t           wr_pt;
    logic             re;
    logic [PT_CW-1:0] rd_idx;
  } mem_req_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/plrt_if.sv
// Valid/ready channel interfaces for the input words and the table entry words.
// Depends on plrt_pkg for the field widths.
`default_nettype none

interface plrt_in_if import plrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [X_W-1:0]    point_x;
  logic [Y_W-1:0]    point_y;

  modport source (output valid, output func, output point_x, output point_y, input ready);
  modport sink   (input valid, input func, input point_x, input point_y, output ready);
endinterface

interface plrt_out_if import plrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  value;
  logic [ADDR_W-1:0] entry_address;
  logic              last;
  logic              overflow;

  modport source (output valid, output value, output entry_address, output last,
                  output overflow, input ready);
  modport sink   (input valid, input value, input entry_address, input last,
                  input overflow, output ready);
endinterface

`default_nettype wire

FILE: hdl/piecewise_linear_ramp_table_generator.sv
// Piecewise linear ramp table: point store, shared divider and sequencer. Append, clear and
// unused words are taken in the idle state. An emit word inside a segment reads its right point,
// picks its entry value and hands it to the entry register; a pass start before it, or a segment
// change after it, adds up to 2 reads and 2 divisions; a final entry adds one more division.
// One word is in work at a time; the entry register lets the next word in while a result waits.
// Reset (rst_ni, asynchronous, active low) clears control state; point store contents are undefined.
`default_nettype none

module piecewise_linear_ramp_table_generator import plrt_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  plrt_in_if.sink                    in_ch,
  plrt_out_if.source                 out_ch,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SH_W = ACC_W - 1 - (GRAD_FRAC_BITS - VAL_FRAC_W);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_RD2  = 4'd3;
  localparam logic [3:0] S_DIVA = 4'd4;
  localparam logic [3:0] S_DIVG = 4'd5;
  localparam logic [3:0] S_EMIT = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]               state_q, state_d;
  logic [Y_W-1:0]           max_y_q, max_y_d;
  logic [TS_W-1:0]          table_size_q, table_size_d;
  logic [CHAN_W-1:0]        channel_q, channel_d;
  logic [PT_CW-1:0]         count_q, count_d;
  logic [PT_AW-1:0]         seg_q, seg_d;
  logic [X_W-1:0]           sx_q, sx_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [GRAD_W-1:0] grad_q, grad_d;
  logic                     dropped_q, dropped_d;
  logic                     pass_start_q, pass_start_d;
  logic                     fin_q, fin_d;
  logic [VAL_W-1:0]         v_q, v_d;
  logic [X_W-1:0]           x0_q, x0_d, x1_q, x1_d;
  logic [Y_W-1:0]           y0_q, y0_d, y1_q, y1_d;
  logic [DIV_DEN_W-1:0]     prod_q, prod_d;
  logic                     out_valid_q, out_valid_d;
  logic [VAL_W-1:0]         out_value_q, out_value_d;
  logic [ADDR_W-1:0]        out_addr_q, out_addr_d;
  logic                     out_last_q, out_last_d;
  logic                     out_ovf_q, out_ovf_d;

  mem_req_t mem_req;
  point_t   rd_pt;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                 in_acc;
  logic                 out_free;
  logic [Y_W-1:0]       eff_my;
  logic [TS_W-1:0]      t_cap;
  logic [TS_W-1:0]      sx_ext;
  logic                 fin_now;
  logic                 end_after;
  logic [PT_CW-1:0]     seg_next;
  logic [SH_W-1:0]      acc_sh;
  logic [VAL_W-1:0]     acc_val;
  logic [Y_W-1:0]       dy_mag;
  logic                 dy_neg;
  logic [DIV_NUM_W-1:0] fin_num;

  plrt_point_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .count_i (count_q),
    .rd_pt_o (rd_pt)
  );

  plrt_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Handshakes
  assign in_ch.ready = (state_q == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_q || out_ch.ready;

  assign out_ch.valid         = out_valid_q;
  assign out_ch.value         = out_value_q;
  assign out_ch.entry_address = out_addr_q;
  assign out_ch.last          = out_last_q;
  assign out_ch.overflow      = out_ovf_q;

  // Derived operands
  always_comb begin
    eff_my    = (max_y_q == '0) ? Y_W'(1) : max_y_q;
    t_cap     = (table_size_q > TS_CAP) ? TS_CAP : table_size_q;
    sx_ext    = {1'b0, sx_q};
    fin_now   = (sx_q != '0) && ((sx_ext + TS_W'(1)) >= t_cap);
    end_after = (sx_ext + TS_W'(2)) >= t_cap;
    seg_next  = {1'b0, seg_q} + PT_CW'(1);
    acc_sh    = acc_q[ACC_W-2:GRAD_FRAC_BITS-VAL_FRAC_W];
    if (acc_q[ACC_W-1]) begin
      acc_val = '0;
    end else if (acc_sh > SH_W'(VAL_MAX)) begin
      acc_val = VAL_MAX;
    end else begin
      acc_val = acc_sh[VAL_W-1:0];
    end
    dy_neg  = (y1_q < y0_q);
    dy_mag  = dy_neg ? (y0_q - y1_q) : (y1_q - y0_q);
    fin_num = DIV_NUM_W'({rd_pt.y, {VAL_FRAC_W{1'b0}}});
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    max_y_d      = max_y_q;
    table_size_d = table_size_q;
    channel_d    = channel_q;
    count_d      = count_q;
    seg_d        = seg_q;
    sx_d         = sx_q;
    acc_d        = acc_q;
    grad_d       = grad_q;
    dropped_d    = dropped_q;
    pass_start_d = pass_start_q;
    fin_d        = fin_q;
    v_d          = v_q;
    x0_d         = x0_q;
    y0_d         = y0_q;
    x1_d         = x1_q;
    y1_d         = y1_q;
    prod_d       = prod_q;
    out_valid_d  = out_valid_q && !out_ch.ready;
    out_value_d  = out_value_q;
    out_addr_d   = out_addr_q;
    out_last_d   = out_last_q;
    out_ovf_d    = out_ovf_q;
    mem_req      = '0;
    div_req      = '0;

    // Configuration writes; the span register has no effect on the ramp
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_X:      ;
        CFG_MAX_Y:      max_y_d      = cfg_data_i[Y_W-1:0];
        CFG_TABLE_SIZE: table_size_d = cfg_data_i[TS_W-1:0];
        CFG_CHANNEL:    channel_d    = cfg_data_i[CHAN_W-1:0];
        default:        ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.func)
            FUNC_APPEND: begin
              if (count_q < PT_CW'(MAX_POINTS)) begin
                mem_req.we      = 1'b1;
                mem_req.wr_addr = count_q[PT_AW-1:0];
                mem_req.wr_pt   = '{x: in_ch.point_x, y: in_ch.point_y};
                count_d         = count_q + PT_CW'(1);
              end else begin
                dropped_d = 1'b1;
              end
            end
            FUNC_EMIT: begin
              if (sx_q == '0) begin
                seg_d        = '0;
                pass_start_d = 1'b1;
                state_d      = S_RD0;
              end else begin
                mem_req.re     = 1'b1;
                mem_req.rd_idx = seg_next;
                state_d        = S_EMIT;
              end
            end
            FUNC_CLEAR: begin
              count_d   = '0;
              seg_d     = '0;
              sx_d      = '0;
              acc_d     = '0;
              grad_d    = '0;
              dropped_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      // Fetch the left and right points of the segment
      S_RD0: begin
        mem_req.re     = 1'b1;
        mem_req.rd_idx = {1'b0, seg_q};
        state_d        = S_RD1;
      end
      S_RD1: begin
        x0_d           = rd_pt.x;
        y0_d           = rd_pt.y;
        mem_req.re     = 1'b1;
        mem_req.rd_idx = seg_next;
        state_d        = S_RD2;
      end
      S_RD2: begin
        x1_d          = rd_pt.x;
        y1_d          = rd_pt.y;
        div_req.start = 1'b1;
        div_req.num   = {y0_q, {GRAD_FRAC_BITS{1'b0}}};
        div_req.den   = DIV_DEN_W'(eff_my);
        state_d       = S_DIVA;
      end
      // Start value; form the gradient divisor meanwhile
      S_DIVA: begin
        prod_d = DIV_DEN_W'(x1_q - x0_q) * DIV_DEN_W'(eff_my);
        if (div_rsp.done) begin
          acc_d = $signed(ACC_W'(div_rsp.quot));
          if (x1_q > x0_q) begin
            div_req.start = 1'b1;
            div_req.num   = {dy_mag, {GRAD_FRAC_BITS{1'b0}}};
            div_req.den   = prod_q;
            state_d       = S_DIVG;
          end else begin
            grad_d  = '0;
            state_d = pass_start_q ? S_EMIT : S_IDLE;
          end
        end
      end
      S_DIVG: begin
        if (div_rsp.done) begin
          grad_d  = dy_neg ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
          state_d = pass_start_q ? S_EMIT : S_IDLE;
        end
      end
      // Pick the entry value: running sum, or the exact final point
      S_EMIT: begin
        pass_start_d = 1'b0;
        fin_d        = fin_now;
        if (fin_now) begin
          div_req.start = 1'b1;
          div_req.num   = fin_num;
          div_req.den   = DIV_DEN_W'(eff_my);
          state_d       = S_FIN;
        end else begin
          v_d     = acc_val;
          state_d = S_OUT;
        end
      end
      S_FIN: begin
        if (div_rsp.done) begin
          v_d     = (div_rsp.quot > DIV_NUM_W'(VAL_MAX)) ? VAL_MAX : div_rsp.quot[VAL_W-1:0];
          state_d = S_OUT;
        end
      end
      // Hand the word over, then advance the sample and maybe the segment, or rewind after the final entry
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = v_q;
          out_addr_d  = {sx_q, channel_q};
          out_last_d  = fin_q;
          out_ovf_d   = dropped_q;
          state_d     = S_IDLE;
          if (fin_q) begin
            sx_d = '0;
          end else begin
            acc_d = acc_q + ACC_W'(grad_q);
            sx_d  = sx_q + X_W'(1);
            if (!end_after && (seg_next < count_q) &&
                ((sx_ext + TS_W'(1)) >= {1'b0, rd_pt.x})) begin
              seg_d   = seg_next[PT_AW-1:0];
              state_d = S_RD0;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      max_y_q      <= Y_W'(255);
      table_size_q <= TS_W'(256);
      channel_q    <= '0;
      count_q      <= '0;
      seg_q        <= '0;
      sx_q         <= '0;
      acc_q        <= '0;
      grad_q       <= '0;
      dropped_q    <= 1'b0;
      pass_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      max_y_q      <= max_y_d;
      table_size_q <= table_size_d;
      channel_q    <= channel_d;
      count_q      <= count_d;
      seg_q        <= seg_d;
      sx_q         <= sx_d;
      acc_q        <= acc_d;
      grad_q       <= grad_d;
      dropped_q    <= dropped_d;
      pass_start_q <= pass_start_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fin_q       <= fin_d;
    v_q         <= v_d;
    x0_q        <= x0_d;
    y0_q        <= y0_d;
    x1_q        <= x1_d;
    y1_q        <= y1_d;
    prod_q      <= prod_d;
    out_value_q <= out_value_d;
    out_addr_q  <= out_addr_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  // Checks
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_seg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> ({1'b0, seg_q} < count_q))
    else $error("segment index beyond stored points");

  a_last_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free && fin_q) |=> (sx_q == '0))
    else $error("final entry did not rewind the sample position");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_ch.func == FUNC_EMIT) |=> (state_q != S_IDLE))
    else $error("emit word dropped without work");

endmodule

`default_nettype wire

FILE: hdl/plrt_point_store.sv
// Control point memory: one write port for appends, one clamped read port with a registered read.
// Depends on plrt_pkg for point_t, mem_req_t and the store depth.
`default_nettype none

module plrt_point_store import plrt_pkg::*; (
  input  wire logic             clk_i,
  input  wire mem_req_t         req_i,
  input  wire logic [PT_CW-1:0] count_i,
  output point_t                rd_pt_o
);

  logic [X_W+Y_W-1:0] pt_ram [MAX_POINTS];
  logic [X_W+Y_W-1:0] rd_data_q;
  logic               empty_q;
  logic [PT_CW-1:0]   last_idx;
  logic [PT_CW-1:0]   rd_idx;

  // Clamp an index past the fill level onto the last stored point
  always_comb begin
    last_idx = count_i - PT_CW'(1);
    rd_idx   = (req_i.rd_idx >= count_i) ? last_idx : req_i.rd_idx;
  end

  // Write on append
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      pt_ram[req_i.wr_addr] <= req_i.wr_pt;
    end
  end

  // Registered read; hold the word until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= pt_ram[rd_idx[PT_AW-1:0]];
      empty_q   <= (count_i == '0);
    end
  end

  // An empty store reads as the origin
  assign rd_pt_o = empty_q ? '0 : point_t'(rd_data_q);

endmodule

`default_nettype wire

FILE: hdl/plrt_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all segment and final-entry divisions.
// Depends on plrt_pkg for the operand widths and the request/response structs.
`default_nettype none

module plrt_divider import plrt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [DIV_DEN_W:0] trial;
  logic [DIV_DEN_W:0] diff;
  logic               ge;

  // One shift-compare-subtract step
  always_comb begin
    trial = {rem_q, quo_q[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start && !busy_q) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = CNT_W'(DIV_NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_NUM_W-2:0], ge};
      rem_d = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and partial results need no reset
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb_piecewise_linear_ramp_table_generator.sv
`timescale 1ns / 100ps
// Self-checking testbench for the piecewise linear ramp table generator: drives point,
// emit and clear words, predicts every table entry word and checks it field by field.
// Depends on plrt_pkg, the channel interfaces in plrt_if and the block's top level.

module tb_piecewise_linear_ramp_table_generator;
  import plrt_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_STRETCH = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 110;
  localparam int SHORT_RUN     = 40;
  localparam int CAPPED_RUN    = 48;

  typedef enum int {
    PACE_FULL,
    PACE_SENDER_SLOW,
    PACE_RECEIVER_SLOW,
    PACE_BOTH_SLOW
  } pace_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [X_W-1:0]    point_x;
    logic [Y_W-1:0]    point_y;
    logic              wait_empty;
  } word_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [ADDR_W-1:0] entry_address;
    logic              last;
    logic              overflow;
  } entry_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  plrt_in_if  in_ch ();
  plrt_out_if out_ch ();

  piecewise_linear_ramp_table_generator uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // Stimulus and expectation stores
  word_t       words_to_send [$];
  entry_t      entries_due [$];
  word_t       live_word;
  bit          offering = 1'b0;
  int unsigned queued_in_phase = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned hold_left = 0;

  // Predicted register file
  logic [X_W-1:0]    cfg_max_x = 12'd255;
  logic [Y_W-1:0]    cfg_max_y = 12'd255;
  logic [TS_W-1:0]   cfg_size  = 13'd256;
  logic [CHAN_W-1:0] cfg_chan  = '0;

  // Predicted ramp state
  logic [X_W-1:0]    px_mem [MAX_POINTS];
  logic [Y_W-1:0]    py_mem [MAX_POINTS];
  logic [PT_CW-1:0]  pts_n   = '0;
  int unsigned       seg     = 0;
  logic [X_W-1:0]    step_x  = '0;
  longint            acc     = 0;
  longint            grad    = 0;
  logic              dropped = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run
  initial begin
    #5_000_000;
    $display("tb_piecewise_linear_ramp_table_generator: FAIL");
    $finish;
  end

  // Count down the long receiver hold-off
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  function automatic longint unsigned full_scale();
    return (cfg_max_y == 0) ? 64'd1 : longint'(cfg_max_y);
  endfunction

  // Points past the end of the list read as the last one, an empty list as the origin
  function automatic logic [X_W-1:0] point_x_at(int unsigned i);
    if (pts_n == 0) return '0;
    if (i >= pts_n) i = pts_n - 1;
    return px_mem[i];
  endfunction

  function automatic logic [Y_W-1:0] point_y_at(int unsigned i);
    if (pts_n == 0) return '0;
    if (i >= pts_n) i = pts_n - 1;
    return py_mem[i];
  endfunction

  // Reload the accumulator from the left point and divide out the new gradient
  function automatic void load_segment();
    logic [X_W-1:0]    x0, x1;
    logic [Y_W-1:0]    y0, y1;
    longint unsigned   my, den, mag, g;
    x0 = point_x_at(seg);
    x1 = point_x_at(seg + 1);
    y0 = point_y_at(seg);
    y1 = point_y_at(seg + 1);
    my = full_scale();
    acc = longint'((longint'(y0) << GRAD_FRAC_BITS) / my);
    grad = 0;
    if (x1 > x0) begin
      den = longint'(x1 - x0) * my;
      mag = (y1 >= y0) ? longint'(y1 - y0) : longint'(y0 - y1);
      g = (mag << GRAD_FRAC_BITS) / den;
      grad = (y1 >= y0) ? longint'(g) : -longint'(g);
    end
  endfunction

  // Advance the predicted state by one accepted word; queue the entry it yields
  task automatic apply_word(input word_t w);
    int unsigned     lim;
    logic            fin;
    longint unsigned v;
    entry_t          e;
    lim = (cfg_size > TS_CAP) ? TS_CAP : cfg_size;
    case (w.func)
      FUNC_APPEND: begin
        if (pts_n < MAX_POINTS) begin
          px_mem[pts_n] = w.point_x;
          py_mem[pts_n] = w.point_y;
          pts_n = pts_n + 1;
        end else begin
          dropped = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        pts_n = '0;
        seg = 0;
        step_x = '0;
        acc = 0;
        grad = 0;
        dropped = 1'b0;
      end
      FUNC_EMIT: begin
        if (step_x == 0) begin
          seg = 0;
          load_segment();
        end
        fin = (step_x != 0) && (32'(step_x) + 1 >= lim);
        if (fin) begin
          v = (longint'(point_y_at(seg + 1)) << VAL_FRAC_W) / full_scale();
        end else if (acc < 0) begin
          v = 0;
        end else begin
          v = longint'(acc) >> (GRAD_FRAC_BITS - VAL_FRAC_W);
        end
        if (v > VAL_MAX) v = VAL_MAX;
        e.value = VAL_W'(v);
        e.entry_address = ADDR_W'(cfg_chan + ENTRY_STRIDE * step_x);
        e.last = fin;
        e.overflow = dropped;
        entries_due.push_back(e);
        if (fin) begin
          step_x = '0;
        end else begin
          acc = acc + grad;
          step_x = step_x + 1;
          if (32'(step_x) + 1 < lim && seg + 1 < pts_n && step_x >= point_x_at(seg + 1)) begin
            seg = seg + 1;
            load_segment();
          end
        end
      end
      default: ;
    endcase
  endtask

  // Input driver: present the next pending word, predict on acceptance
  always @(posedge clk) begin : word_drive
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_word(live_word);
        offering = 1'b0;
      end
      if (!offering && words_to_send.size() != 0 &&
          !(words_to_send[0].wait_empty && entries_due.size() != 0) &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        live_word = words_to_send.pop_front();
        offering = 1'b1;
        in_ch.func <= live_word.func;
        in_ch.point_x <= live_word.point_x;
        in_ch.point_y <= live_word.point_y;
      end
      in_ch.valid <= offering;
    end
  end

  // Output monitor: compare each entry word with the oldest prediction
  always @(posedge clk) begin : entry_check
    entry_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (entries_due.size() == 0) begin
          $error("entry word with nothing expected: entry_address %0d", out_ch.entry_address);
          mismatches++;
        end else begin
          want = entries_due.pop_front();
          if (out_ch.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_ch.value);
            mismatches++;
          end
          if (out_ch.entry_address !== want.entry_address) begin
            $error("entry_address: expected %0d, got %0d", want.entry_address,
                   out_ch.entry_address);
            mismatches++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_ch.last);
            mismatches++;
          end
          if (out_ch.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_ch.overflow);
            mismatches++;
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  task automatic push_word(input logic [FUNC_W-1:0] f, input int unsigned x = 0,
                           input int unsigned y = 0, input bit hold = 1'b0);
    words_to_send.push_back('{func: f, point_x: X_W'(x), point_y: Y_W'(y), wait_empty: hold});
    queued_in_phase++;
  endtask

  function automatic int unsigned pick_y();
    return ($urandom_range(0, 1) != 0) ? $urandom_range(0, cfg_max_y) : $urandom_range(0, 4095);
  endfunction

  // Wait until every word is in, every entry is out, and the block has settled
  task automatic wait_block_idle();
    while (words_to_send.size() != 0 || offering || entries_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(data);
    case (idx)
      CFG_MAX_X:      cfg_max_x = X_W'(data);
      CFG_MAX_Y:      cfg_max_y = Y_W'(data);
      CFG_TABLE_SIZE: cfg_size = TS_W'(data);
      default:        cfg_chan = CHAN_W'(data);
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int unsigned mx, input int unsigned my,
                           input int unsigned ts, input int unsigned ch);
    write_reg(CFG_MAX_X, mx);
    write_reg(CFG_MAX_Y, my);
    write_reg(CFG_TABLE_SIZE, ts);
    write_reg(CFG_CHANNEL, ch);
  endtask

  task automatic set_pace(input pace_e p);
    case (p)
      PACE_SENDER_SLOW:   begin send_idle_pct <= 88; rcv_stall_pct <= 0;  end
      PACE_RECEIVER_SLOW: begin send_idle_pct <= 0;  rcv_stall_pct <= 88; end
      PACE_BOTH_SLOW:     begin send_idle_pct <= 18; rcv_stall_pct <= 18; end
      default:            begin send_idle_pct <= 0;  rcv_stall_pct <= 0;  end
    endcase
  endtask

  initial begin : stimulus
    int unsigned ts, mx, my, n_pts, n_emit, lim;
    int unsigned xs [$];
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_APPEND;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_X;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, unused code, non-rising x, steep rise past full scale, fall
    push_word(FUNC_EMIT);
    push_word(FUNC_UNUSED, 4095, 4095);
    push_word(FUNC_APPEND, 0, 4095);
    push_word(FUNC_APPEND, 0, 0);
    push_word(FUNC_APPEND, 1, 4095);
    push_word(FUNC_APPEND, 4095, 0);
    repeat (5) push_word(FUNC_EMIT);
    push_word(FUNC_CLEAR);
    push_word(FUNC_EMIT);
    wait_block_idle();

    // Directed: zero full scale, one-entry table, top channel slot
    configure(4095, 0, 1, 3);
    push_word(FUNC_CLEAR, 0, 0, 1'b1);
    push_word(FUNC_APPEND, 0, 10);
    push_word(FUNC_APPEND, 5, 4095);
    repeat (3) push_word(FUNC_EMIT);
    push_word(FUNC_APPEND, 7, 1);
    push_word(FUNC_EMIT);

    // Random phases: well-formed curves and passes, with noise and broken lists mixed in
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_block_idle();
      ts = (ph == 4) ? 2 : (ph == 6) ? 4096 : $urandom_range(3, 40);
      mx = (ts > 64) ? $urandom_range(20, 60) : ts - 1;
      case (ph % 4)
        0:       my = 1;
        1:       my = 4095;
        2:       my = 255;
        default: my = $urandom_range(1, 4095);
      endcase
      configure(mx, my, ts, $urandom_range(0, 3));
      set_pace(pace_e'(ph % 4));
      if (ph % 5 == 2) hold_left <= STALL_STRETCH;
      queued_in_phase = 0;
      while (queued_in_phase < PHASE_WORDS) begin
        xs.delete();
        n_pts = $urandom_range(2, 8);
        xs.push_back(0);
        repeat (n_pts - 2) xs.push_back($urandom_range(0, cfg_max_x));
        xs.push_back(cfg_max_x);
        xs.sort();
        if ($urandom_range(0, 5) == 0) xs.reverse();
        if ($urandom_range(0, 7) != 0) push_word(FUNC_CLEAR, 0, 0, $urandom_range(0, 3) == 0);
        foreach (xs[i]) push_word(FUNC_APPEND, xs[i], pick_y());
        lim = (cfg_size > TS_CAP) ? TS_CAP : cfg_size;
        n_emit = ((lim <= 64) ? lim : $urandom_range(30, 60)) + $urandom_range(0, 2);
        repeat (n_emit) begin
          if ($urandom_range(0, 11) == 0) begin
            push_word(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 4095),
                      $urandom_range(0, 4095));
          end
          push_word(FUNC_EMIT);
        end
      end
    end

    // Overfill the store, walk the first segments, then run past the missing right point
    wait_block_idle();
    configure(255, $urandom_range(1, 4095), 300, 2);
    set_pace(PACE_FULL);
    push_word(FUNC_CLEAR, 0, 0, 1'b1);
    for (int i = 0; i < MAX_POINTS + 3; i++) push_word(FUNC_APPEND, i, pick_y());
    repeat (SHORT_RUN) push_word(FUNC_EMIT);
    push_word(FUNC_CLEAR);
    push_word(FUNC_APPEND, 0, pick_y());
    repeat (2) push_word(FUNC_EMIT);

    // Entries at the capped table size over the widest span
    wait_block_idle();
    configure(4095, $urandom_range(1, 4095), 8191, $urandom_range(0, 3));
    push_word(FUNC_CLEAR, 0, 0, 1'b1);
    push_word(FUNC_APPEND, 0, pick_y());
    push_word(FUNC_APPEND, $urandom_range(1, 40), pick_y());
    push_word(FUNC_APPEND, 4095, pick_y());
    repeat (CAPPED_RUN) push_word(FUNC_EMIT);

    wait_block_idle();
    if (mismatches == 0) begin
      $display("tb_piecewise_linear_ramp_table_generator: PASS");
    end else begin
      $display("tb_piecewise_linear_ramp_table_generator: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/plrt_pkg.sv
hdl/plrt_if.sv
hdl/plrt_point_store.sv
hdl/plrt_divider.sv
hdl/piecewise_linear_ramp_table_generator.sv
tb/sv/tb_piecewise_linear_ramp_table_generator.sv
